// File: hw/rtl/rurf_pkg.sv
// ============================================================================
// rurf_pkg
// Shared types and constants of the redundant update filter cache.
// ============================================================================
package rurf_pkg;

    localparam int ACTION_W = 2;
    localparam int OBJ_W    = 32;
    localparam int METHOD_W = 4;
    localparam int KEY_W    = OBJ_W + METHOD_W;
    localparam int HASH_W   = 32;

    // Input tdata: object_id, method_id, value_hash, zero-filled to whole bytes
    localparam int IN_DATA_W  = ((OBJ_W + METHOD_W + HASH_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    // Action codes carried in tuser
    localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INVAL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Multiplier of the home-slot mix
    localparam logic [31:0] MIX_MULT = 32'h045d_9f3b;

    // Entries of the queue between classifier and probe engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [HASH_W-1:0]   hash;
    } req_t;

    typedef struct packed {
        logic valid;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// File: hw/rtl/rurf_front.sv
// ============================================================================
// rurf_front
// Accepts transactions, forms the key and mixes it into a home slot.
// ============================================================================
module rurf_front #(
    parameter int ADDR_W = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              enable,
    input  logic                              in_tvalid,
    output logic                              in_tready,
    input  logic [rurf_pkg::IN_DATA_W-1:0]    in_tdata,
    input  logic [rurf_pkg::ACTION_W-1:0]     in_tuser,
    input  rurf_pkg::q_status_t               q_status,
    output logic                              push,
    output rurf_pkg::req_t                    push_req,
    output logic [ADDR_W-1:0]                 push_home
);

    logic           s1_valid_reg;
    rurf_pkg::req_t s1_req_reg;
    logic [31:0]    s1_mix_reg;
    logic           s2_valid_reg;
    rurf_pkg::req_t s2_req_reg;
    logic [31:0]    s2_prod_reg;

    rurf_pkg::req_t in_req;
    logic [31:0]    key_lo;
    logic [31:0]    mix_x;
    logic [31:0]    mix_fin;
    logic           s1_ready;
    logic           s2_ready;

    // Unpack the bus fields
    always_comb
    begin
        in_req.action = in_tuser;
        in_req.key    = {in_tdata[rurf_pkg::OBJ_W-1:0],
                         in_tdata[rurf_pkg::OBJ_W +: rurf_pkg::METHOD_W]};
        in_req.hash   = in_tdata[rurf_pkg::KEY_W +: rurf_pkg::HASH_W];
        // key is {object_id, method_id}; object_id is bits [31:0] of tdata
        key_lo        = in_req.key[31:0];
        mix_x         = in_tdata[31:0] ^ key_lo;
    end

    assign s2_ready  = !s2_valid_reg || !q_status.full;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_tready = s1_ready && enable;

    assign mix_fin   = s2_prod_reg ^ (s2_prod_reg >> 16);
    assign push      = s2_valid_reg && !q_status.full;
    assign push_req  = s2_req_reg;
    assign push_home = mix_fin[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_tvalid && enable;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_tvalid && in_tready)
        begin
            s1_req_reg <= in_req;
            s1_mix_reg <= mix_x ^ (mix_x >> 16);
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_req_reg  <= s1_req_reg;
            s2_prod_reg <= s1_mix_reg * rurf_pkg::MIX_MULT;
        end
    end

endmodule

// File: hw/rtl/rurf_queue.sv
// ============================================================================
// rurf_queue
// Short request queue between the classifier and the probe engine.
// ============================================================================
module rurf_queue #(
    parameter int ADDR_W = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rurf_pkg::req_t      push_req,
    input  logic [ADDR_W-1:0]   push_home,
    input  logic                pop,
    output rurf_pkg::req_t      head_req,
    output logic [ADDR_W-1:0]   head_home,
    output rurf_pkg::q_status_t status
);

    rurf_pkg::req_t                 req_mem_reg  [rurf_pkg::QUEUE_DEPTH];
    logic [ADDR_W-1:0]              home_mem_reg [rurf_pkg::QUEUE_DEPTH];
    logic [rurf_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [rurf_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [rurf_pkg::QCNT_W-1:0]    count_reg;
    logic [rurf_pkg::QCNT_W-1:0]    count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == rurf_pkg::QCNT_W'(rurf_pkg::QUEUE_DEPTH));
    assign head_req     = req_mem_reg[rd_ptr_reg];
    assign head_home    = home_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            req_mem_reg[wr_ptr_reg]  <= push_req;
            home_mem_reg[wr_ptr_reg] <= push_home;
        end
    end

endmodule

// File: hw/rtl/rurf_engine.sv
// ============================================================================
// rurf_engine
// Probe engine: walks the slot table, updates it and returns the answer.
// ============================================================================
module rurf_engine #(
    parameter int TABLE_DEPTH = 16384,
    parameter int PROBE_LIMIT = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rurf_pkg::q_status_t                 q_status,
    input  rurf_pkg::req_t                      head_req,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      head_home,
    output logic                                pop,
    output logic                                ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_unchanged
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  LAST_PROBE = CNT_W'(PROBE_LIMIT - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_REPLY = 2'd3;

    rurf_pkg::entry_t mem_ram [TABLE_DEPTH];
    rurf_pkg::entry_t rd_data_reg;

    logic [1:0]        state_reg,        state_next;
    rurf_pkg::req_t    cur_req_reg,      cur_req_next;
    logic [ADDR_W-1:0] idx_reg,          idx_next;
    logic [CNT_W-1:0]  cnt_reg,          cnt_next;
    logic              sweep_reply_reg,  sweep_reply_next;
    logic              out_valid_reg,    out_valid_next;
    logic              out_unchanged_reg, out_unchanged_next;

    logic              out_free;
    logic [ADDR_W-1:0] rd_addr;
    logic              ram_we;
    rurf_pkg::entry_t  ram_wdata;
    logic              hit;
    logic              decided;
    logic              is_check;

    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_unchanged = out_unchanged_reg;
    // Hold off new transactions during the clearing pass after reset
    assign ready         = !((state_reg == ST_SWEEP) && !sweep_reply_reg);

    assign is_check = (cur_req_reg.action == rurf_pkg::ACT_CHECK);
    assign hit      = rd_data_reg.valid && (rd_data_reg.key == cur_req_reg.key);
    assign decided  = !rd_data_reg.valid || hit || (cnt_reg == LAST_PROBE);

    always_comb
    begin
        state_next         = state_reg;
        cur_req_next       = cur_req_reg;
        idx_next           = idx_reg;
        cnt_next           = cnt_reg;
        sweep_reply_next   = sweep_reply_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_unchanged_next = out_unchanged_reg;
        pop                = 1'b0;
        rd_addr            = idx_reg;
        ram_we             = 1'b0;
        ram_wdata.valid    = 1'b1;
        ram_wdata.key      = cur_req_reg.key;
        ram_wdata.hash     = is_check ? cur_req_reg.hash : '0;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = head_home;
                if (!q_status.empty)
                begin
                    pop          = 1'b1;
                    cur_req_next = head_req;
                    idx_next     = head_home;
                    cnt_next     = '0;
                    case (head_req.action)
                        rurf_pkg::ACT_CHECK,
                        rurf_pkg::ACT_INVAL:
                        begin
                            state_next = ST_PROBE;
                        end
                        rurf_pkg::ACT_CLEAR:
                        begin
                            state_next       = ST_SWEEP;
                            idx_next         = '0;
                            sweep_reply_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                if (decided)
                begin
                    // Hold the read address so the slot stays visible while stalled
                    if (out_free)
                    begin
                        ram_we             = is_check || hit;
                        out_valid_next     = 1'b1;
                        out_unchanged_next = is_check && hit &&
                                             (rd_data_reg.hash == cur_req_reg.hash);
                        state_next         = ST_IDLE;
                    end
                end
                else
                begin
                    // Advance to the next slot, wrapping at the table end
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT)
                begin
                    state_next       = sweep_reply_reg ? ST_REPLY : ST_IDLE;
                    sweep_reply_next = 1'b0;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_unchanged_next = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            sweep_reply_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
            sweep_reply_reg <= sweep_reply_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_req_reg       <= cur_req_next;
        out_unchanged_reg <= out_unchanged_next;
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            mem_ram[idx_reg] <= ram_wdata;
        end
        rd_data_reg <= mem_ram[rd_addr];
    end

endmodule

// File: hw/rtl/redundant_update_filter_cache.sv
// ============================================================================
// redundant_update_filter_cache
// Filters updates whose key already holds the same value hash.
// ============================================================================
// Each slave transaction carries an action in tuser (check, invalidate or
// clear) and an object id, method id and value hash in tdata; each one yields
// exactly one master transaction whose bit 0 is the "unchanged" answer. A
// classifier pipeline forms the key {object_id, method_id}, mixes it by
// xor-shift and a 32-bit multiply into a home slot over two register stages,
// and hands it through a two-entry queue to a probe engine. The engine owns a
// single table memory of TABLE_DEPTH entries (valid, key, hash) with one
// registered read port and one write port, and probes up to PROBE_LIMIT
// consecutive slots, one slot read per cycle. A check or invalidate pops its
// request and then reads the probed slots in turn; an unused action is
// popped and answered zero. A clear sweeps the whole memory, one entry per
// cycle, and then answers. After reset the same clearing pass runs and no
// transaction is accepted until it is done. A stalled master side holds the
// engine once the output register is full; the classifier and queue keep
// accepting until they fill.
module redundant_update_filter_cache #(
    parameter int TABLE_DEPTH = 16384,   // power of two, 16 to 65536
    parameter int PROBE_LIMIT = 4        // 1 to 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // object_id [31:0], method_id [35:32], value_hash [67:36], zero fill
    input  logic [rurf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action [1:0]
    input  logic [rurf_pkg::ACTION_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // unchanged [0], zero fill
    output logic [rurf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    rurf_pkg::q_status_t q_status;
    rurf_pkg::req_t      push_req;
    rurf_pkg::req_t      head_req;
    logic [ADDR_W-1:0]   push_home;
    logic [ADDR_W-1:0]   head_home;
    logic                push;
    logic                pop;
    logic                eng_ready;
    logic                unchanged;

    // Classify: unpack the transaction and compute its home slot
    rurf_front #(
        .ADDR_W (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (eng_ready),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_req  (push_req),
        .push_home (push_home)
    );

    // Decouple classification from the table walk
    rurf_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .push_home (push_home),
        .pop       (pop),
        .head_req  (head_req),
        .head_home (head_home),
        .status    (q_status)
    );

    // Walk the probe sequence, update the table and register the answer
    rurf_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_req      (head_req),
        .head_home     (head_home),
        .pop           (pop),
        .ready         (eng_ready),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_unchanged (unchanged)
    );

    assign m_axis_tdata = {{(rurf_pkg::OUT_DATA_W - 1){1'b0}}, unchanged};

    // Engine never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // Classifier never pushes into a full queue
    a_push_nonfull: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    // No transaction is taken while the post-reset clearing pass runs
    a_no_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
        !eng_ready |-> !(s_axis_tvalid && s_axis_tready))
        else $error("transaction accepted during table clearing");

    // A push without a pop in the same cycle leaves the queue non-empty
    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !q_status.empty)
        else $error("queue lost an entry");

endmodule

// File: sim/redundant_update_filter_cache_test.sv
// ============================================================================
// redundant_update_filter_cache_test
// Self-checking stream testbench of the redundant update filter cache.
// ============================================================================
// Drive check, invalidate, clear and unused-action transactions into the
// slave side and compare each master transaction with an answer worked out
// by a local copy of the probe table. Keys are mostly drawn from small sets
// whose home slots crowd into a few neighboring slots (one set straddles the
// table wrap), so probe chains fill, overflow and evict. Run directed edge
// cases first, then random traffic under several idling mixes and one long
// master-side hold-off that backs the block up into its input.
// ============================================================================
module redundant_update_filter_cache_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH = 16384;
    localparam int          PROBE_LIMIT = 4;
    localparam int          HALF_PERIOD = 2;
    localparam logic [31:0] KEY_MIX     = 32'h045d_9f3b;
    // Zero bits above value_hash in tdata
    localparam int          FILL_W      = rurf_pkg::IN_DATA_W - rurf_pkg::KEY_W
                                          - rurf_pkg::HASH_W;
    // Action code left unused by the block: ignored, answer zero
    localparam logic [rurf_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // object_id [31:0], method_id [35:32], value_hash [67:36], zero fill
    logic [rurf_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
    // action [1:0]
    logic [rurf_pkg::ACTION_W-1:0]      s_axis_tuser = rurf_pkg::ACT_CHECK;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // unchanged [0], zero fill
    logic [rurf_pkg::OUT_DATA_W-1:0]    m_axis_tdata;

    // Local copy of the probe table
    bit                             slot_valid [TABLE_DEPTH];
    logic [rurf_pkg::KEY_W-1:0]     slot_key   [TABLE_DEPTH];
    logic [rurf_pkg::HASH_W-1:0]    slot_hash  [TABLE_DEPTH];

    // Answers still owed by the block, oldest first
    bit                             answer_q [$];
    // Keys whose home slots lie close together
    logic [rurf_pkg::KEY_W-1:0]     crowded_keys [$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;

    int mismatch_count = 0;
    int answers_seen   = 0;
    int hits_seen      = 0;
    int checks_sent    = 0;
    int invals_sent    = 0;
    int clears_sent    = 0;
    int unused_sent    = 0;

    redundant_update_filter_cache #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Mix the key by xor-shift and multiply into its home slot
    function automatic int home_slot_of(input logic [rurf_pkg::KEY_W-1:0] key);
        logic [31:0] k;
        k = key[rurf_pkg::KEY_W-1:4] ^ key[31:0];
        k = k ^ (k >> 16);
        k = k * KEY_MIX;
        k = k ^ (k >> 16);
        return int'(k % TABLE_DEPTH);
    endfunction

    // Apply one transaction to the local table and return the unchanged answer
    function automatic bit predict_answer(input logic [rurf_pkg::ACTION_W-1:0] act,
                                          input logic [rurf_pkg::KEY_W-1:0] key,
                                          input logic [rurf_pkg::HASH_W-1:0] hash);
        int home;
        int idx;
        home = home_slot_of(key);
        if (act == rurf_pkg::ACT_CHECK)
        begin
            for (int i = 0; i < PROBE_LIMIT; i++)
            begin
                idx = (home + i) % TABLE_DEPTH;
                if (!slot_valid[idx])
                begin
                    slot_valid[idx] = 1'b1;
                    slot_key[idx]   = key;
                    slot_hash[idx]  = hash;
                    return 1'b0;
                end
                if (slot_key[idx] == key)
                begin
                    if (slot_hash[idx] == hash)
                        return 1'b1;
                    slot_hash[idx] = hash;
                    return 1'b0;
                end
            end
            // Whole chain held by other keys: evict the last probed slot
            idx = (home + PROBE_LIMIT - 1) % TABLE_DEPTH;
            slot_valid[idx] = 1'b1;
            slot_key[idx]   = key;
            slot_hash[idx]  = hash;
        end
        else if (act == rurf_pkg::ACT_INVAL)
        begin
            for (int i = 0; i < PROBE_LIMIT; i++)
            begin
                idx = (home + i) % TABLE_DEPTH;
                if (!slot_valid[idx])
                    return 1'b0;
                if (slot_key[idx] == key)
                begin
                    slot_hash[idx] = '0;
                    return 1'b0;
                end
            end
        end
        else if (act == rurf_pkg::ACT_CLEAR)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_valid[i] = 1'b0;
        end
        return 1'b0;
    endfunction

    // Collect keys whose home slot falls within span slots from base
    task automatic find_crowded_keys(input int base, input int span, input int count);
        logic [rurf_pkg::KEY_W-1:0] key;
        int found;
        int slot_gap;
        found = 0;
        while (found < count)
        begin
            key[rurf_pkg::KEY_W-1:4] = $urandom;
            key[3:0]                 = 4'($urandom_range(0, 15));
            slot_gap = (home_slot_of(key) - base + TABLE_DEPTH) % TABLE_DEPTH;
            if (slot_gap < span)
            begin
                crowded_keys.push_back(key);
                found++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Slave side
    // ------------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, and record its answer.
    // Leave tvalid high afterwards so back-to-back transactions never drop it.
    task automatic send_txn(input logic [rurf_pkg::ACTION_W-1:0] act,
                            input logic [rurf_pkg::KEY_W-1:0] key,
                            input logic [rurf_pkg::HASH_W-1:0] hash);
        bit answer;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{FILL_W{1'b0}}, hash, key[3:0], key[rurf_pkg::KEY_W-1:4]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        answer = predict_answer(act, key, hash);
        answer_q.push_back(answer);
        hits_seen += answer;
        case (act)
            rurf_pkg::ACT_CHECK: checks_sent++;
            rurf_pkg::ACT_INVAL: invals_sent++;
            rurf_pkg::ACT_CLEAR: clears_sent++;
            default:             unused_sent++;
        endcase
    endtask

    // Drop tvalid and wait for a clock edge before anything new is driven
    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Pick a hash mostly from a small set so that repeats, and thus hits, are common
    function automatic logic [rurf_pkg::HASH_W-1:0] pick_hash();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            5:       return $urandom;
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Master side and checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Stall at random; a pending hold-off count wins and is counted down here
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each master transaction with the oldest owed answer
    always @(posedge clk)
    begin
        bit answer;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (answer_q.size() == 0)
            begin
                report_mismatch($sformatf("result 0x%02h with no transaction pending",
                                          m_axis_tdata));
            end
            else
            begin
                answer = answer_q.pop_front();
                answers_seen++;
                if (m_axis_tdata !== {{(rurf_pkg::OUT_DATA_W-1){1'b0}}, answer})
                    report_mismatch($sformatf("result %0d: got 0x%02h, expected unchanged=%0d",
                                              answers_seen, m_axis_tdata, answer));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, hash update, invalidate then zero-hash hit, unused action
    task automatic test_field_edges();
        logic [rurf_pkg::KEY_W-1:0] absent_key;
        absent_key = {32'h5a5a_a5a5, 4'h6};
        send_txn(rurf_pkg::ACT_CHECK, '0, '0);
        send_txn(rurf_pkg::ACT_CHECK, '0, '0);
        send_txn(rurf_pkg::ACT_CHECK, '1, '1);
        send_txn(rurf_pkg::ACT_CHECK, '1, '1);
        send_txn(rurf_pkg::ACT_CHECK, '1, 32'h1234_5678);
        send_txn(rurf_pkg::ACT_INVAL, '1, '1);
        // Invalidated entry now holds hash zero
        send_txn(rurf_pkg::ACT_CHECK, '1, '0);
        // Absent key: invalidate stops at an empty slot
        send_txn(rurf_pkg::ACT_INVAL, absent_key, '1);
        send_txn(ACT_UNUSED, '1, '1);
        send_txn(rurf_pkg::ACT_CHECK, '0, '1);
        stop_sending();
    endtask

    // Five keys sharing the last home slot: the chain wraps and overflows
    task automatic test_probe_chain();
        for (int i = 0; i < 5; i++)
            send_txn(rurf_pkg::ACT_CHECK, crowded_keys[i], i);
        // Fourth key was evicted by the fifth; it evicts the fifth in turn
        send_txn(rurf_pkg::ACT_CHECK, crowded_keys[3], 3);
        send_txn(rurf_pkg::ACT_CHECK, crowded_keys[2], 2);
        // Fifth key is gone: invalidate walks the full chain with no match
        send_txn(rurf_pkg::ACT_INVAL, crowded_keys[4], '1);
        send_txn(rurf_pkg::ACT_INVAL, crowded_keys[1], '1);
        send_txn(rurf_pkg::ACT_CHECK, crowded_keys[1], '0);
        stop_sending();
    endtask

    // Clear empties the table; invalidate after it stops at the first gap
    task automatic test_table_clear();
        send_txn(rurf_pkg::ACT_CLEAR, '1, '1);
        send_txn(rurf_pkg::ACT_CHECK, crowded_keys[0], '0);
        send_txn(rurf_pkg::ACT_CHECK, '0, '0);
        send_txn(rurf_pkg::ACT_INVAL, crowded_keys[2], '0);
        stop_sending();
    endtask

    // Mostly well-formed traffic on crowded keys, with noise and rare clears
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        logic [rurf_pkg::ACTION_W-1:0] act;
        logic [rurf_pkg::KEY_W-1:0]    key;
        logic [rurf_pkg::HASH_W-1:0]   hash;
        int                            r;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            r    = $urandom_range(0, 99);
            key  = crowded_keys[$urandom_range(0, crowded_keys.size() - 1)];
            hash = pick_hash();
            act  = rurf_pkg::ACT_CHECK;
            if (r < 13)
            begin
                // Noise: keys and hashes anywhere in their ranges
                key[rurf_pkg::KEY_W-1:4] = $urandom;
                key[3:0]                 = 4'($urandom_range(0, 15));
                hash                     = $urandom;
                if (r < 1)
                    act = rurf_pkg::ACT_CLEAR;
                else if (r < 3)
                    act = ACT_UNUSED;
                else if (r < 6)
                    act = rurf_pkg::ACT_INVAL;
            end
            else if (r < 25)
            begin
                act = rurf_pkg::ACT_INVAL;
            end
            send_txn(act, key, hash);
        end
        stop_sending();
    endtask

    // Hold the master side off for a long stretch while the slave side keeps
    // offering, so the block fills and drops tready on its input
    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        @(posedge clk);
        hold_left <= 400;
        for (int n = 0; n < 30; n++)
            send_txn(rurf_pkg::ACT_CHECK,
                     crowded_keys[$urandom_range(0, crowded_keys.size() - 1)],
                     pick_hash());
        stop_sending();
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            slot_valid[i] = 1'b0;
        // Directed chain first: home slot on the last entry, probes wrap
        find_crowded_keys(TABLE_DEPTH - 1, 1, 5);
        find_crowded_keys(TABLE_DEPTH - 3, 4, 8);
        find_crowded_keys($urandom_range(0, TABLE_DEPTH - 1), 3, 8);
        find_crowded_keys($urandom_range(0, TABLE_DEPTH - 1), 6, 6);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_field_edges();
        test_probe_chain();
        test_table_clear();
        test_random_traffic(0, 0, 200);
        test_random_traffic(86, 0, 150);
        test_random_traffic(0, 86, 150);
        test_random_traffic(11, 11, 200);
        test_output_backpressure();

        // Drain, then watch a while longer for stray results
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d checks (%0d unchanged), %0d invalidates, %0d clears, %0d unused",
                 checks_sent, hits_seen, invals_sent, clears_sent, unused_sent);
        $display("%0d results compared, %0d mismatches", answers_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("redundant_update_filter_cache_test: PASS");
        else
            $display("redundant_update_filter_cache_test: FAIL");
        $finish;
    end

    // Clears and the reset sweep cost a full table pass each; allow plenty
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", answer_q.size());
        $display("redundant_update_filter_cache_test: FAIL");
        $finish;
    end

endmodule

// File: redundant_update_filter_cache.f
hw/rtl/rurf_pkg.sv
hw/rtl/rurf_front.sv
hw/rtl/rurf_queue.sv
hw/rtl/rurf_engine.sv
hw/rtl/redundant_update_filter_cache.sv
sim/redundant_update_filter_cache_test.sv
